FILE: rtl/lrc_pkg.sv
// Package with shared types and constants for the byte budget LRU cache.
package lrc_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = 5;
    localparam int LINK_W    = 6;
    localparam int SIZE_W    = 32;
    localparam int REF_W     = 16;
    localparam int TOTAL_W   = 38;
    localparam int CNT_W     = 32;
    localparam int BUSY_W    = 6;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);
    localparam logic [REF_W-1:0]  REF_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [1:0] CMD_ATTACH = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DETACH = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [SIZE_W-1:0] new_size;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   result_index;
        logic [SIZE_W-1:0]  entry_size;
        logic [REF_W-1:0]   ref_count;
        logic               is_removal;
        logic [BUSY_W-1:0]  busy_count;
        logic [TOTAL_W-1:0] total_bytes;
        logic [CNT_W-1:0]   eviction_total;
        logic               last;
    } t_rsp;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_REQ,
        OP_READ_TAIL,
        OP_READ_CUR,
        OP_ATTACH,
        OP_DETACH,
        OP_INVALID,
        OP_REMOVE,
        OP_SKIP_BUSY,
        OP_ALLOC,
        OP_NO_FREE,
        OP_SUMMARY
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       req_ok;
        logic       over_limit;
        logic       under_limit;
        logic       tail_nil;
        logic       cur_nil;
        logic       cur_busy;
        logic       free_empty;
    } t_stat;

endpackage

FILE: rtl/lru_refcount_byte_budget_cache.sv
// Top level of the byte budget LRU cache with reference counts.
// One request is handled at a time. Attach and detach present their result
// once the addressed entry has been read, and a new request is taken only
// after that. Add presents a result for each evicted entry before its final
// one, and clear walks the recency list from the oldest entry; the list walk
// reads one entry per cycle from the link registers while no result is held
// off, and each eviction re-reads the new oldest entry before deciding to
// continue. A receiver that holds off a result stalls the request.
module lru_refcount_byte_budget_cache import lrc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_req               i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output t_rsp               o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    lrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lrc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_rsp      (o_rsp)
    );

    // A request is only taken while no result is pending delivery.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (!o_valid || i_ready))
        else $error("request accepted while result pending");

    // The status code of a delivered result is always a defined code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_NO_FREE ||
                     o_rsp.status == ST_INVALID))
        else $error("bad status");

    // A removal is never the final result of a request.
    a_removal_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.is_removal) |-> !o_rsp.last)
        else $error("removal marked last");

endmodule

FILE: rtl/lrc_datapath.sv
// Datapath with entry memories, recency list links, free stack and counters.
module lrc_datapath import lrc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TOTAL_W-1:0]  i_cfg_data,
    input  t_req                i_req,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output t_rsp                o_rsp
);

    logic [LINK_W-1:0]  r_next [ENTRIES];
    logic [LINK_W-1:0]  r_prev [ENTRIES];
    logic [REF_W-1:0]   r_refs [ENTRIES];
    logic [SIZE_W-1:0]  r_bytes [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_free [ENTRIES];
    logic [LINK_W-1:0]  r_free_depth;
    logic [LINK_W-1:0]  r_head, r_tail;
    logic [TOTAL_W-1:0] r_total, r_limit;
    logic [CNT_W-1:0]   r_removed;
    logic [BUSY_W-1:0]  r_busy;
    t_req               r_req;

    // Registered read of the addressed entry.
    logic [IDX_W-1:0]   r_cur;
    logic               r_cur_nil;
    logic [LINK_W-1:0]  r_cur_next, r_cur_prev;
    logic [REF_W-1:0]   r_cur_refs;
    logic [SIZE_W-1:0]  r_cur_bytes;
    logic               r_cur_valid;

    logic [LINK_W-1:0]  rd_addr;
    logic [IDX_W-1:0]   rd_idx;
    logic [LINK_W-1:0]  new_head, new_tail;
    logic [TOTAL_W-1:0] sub_total, add_total;
    logic [TOTAL_W:0]   add_wide;
    logic [REF_W-1:0]   inc_ref, dec_ref;
    logic [IDX_W-1:0]   pop_idx;
    logic [LINK_W-1:0]  pop_depth;

    always_comb begin
        rd_addr = {r_cur_nil, r_cur};
        case (i_cmd.op)
            OP_READ_REQ: rd_addr = {1'b0, r_req.entry_index};
            OP_READ_TAIL: rd_addr = r_tail;
            OP_REMOVE, OP_SKIP_BUSY: rd_addr = r_cur_prev;
            default: rd_addr = {r_cur_nil, r_cur};
        endcase
        rd_idx = rd_addr[IDX_W-1:0];
    end

    assign sub_total = (r_total >= TOTAL_W'(r_cur_bytes)) ?
        r_total - TOTAL_W'(r_cur_bytes) : '0;
    assign add_wide  = {1'b0, r_total} + (TOTAL_W+1)'(r_req.new_size);
    assign add_total = add_wide[TOTAL_W] ? TOTAL_MAX : add_wide[TOTAL_W-1:0];
    assign inc_ref   = (r_cur_refs == REF_MAX) ? r_cur_refs : r_cur_refs + 1'b1;
    assign dec_ref   = (r_cur_refs == '0) ? r_cur_refs : r_cur_refs - 1'b1;
    assign pop_depth = r_free_depth - 1'b1;
    assign pop_idx   = r_free[pop_depth[IDX_W-1:0]];

    // Head and tail after unlinking the current entry.
    always_comb begin
        new_head = (r_head == {1'b0, r_cur}) ? r_cur_next : r_head;
        new_tail = (r_tail == {1'b0, r_cur}) ? r_cur_prev : r_tail;
    end

    assign o_stat.cmd         = r_req.cmd;
    assign o_stat.req_ok      = r_cur_valid;
    assign o_stat.over_limit  = r_total > r_limit;
    assign o_stat.under_limit = r_total < r_limit;
    assign o_stat.tail_nil    = r_tail == NIL;
    assign o_stat.cur_nil     = r_cur_nil;
    assign o_stat.cur_busy    = r_cur_refs != '0;
    assign o_stat.free_empty  = r_free_depth == '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_req <= i_req;
        end
        r_cur       <= rd_idx;
        r_cur_nil   <= rd_addr[LINK_W-1];
        // The removed entry's next link is what its predecessor receives.
        r_cur_next  <= (i_cmd.op == OP_REMOVE) ? r_cur_next : r_next[rd_idx];
        r_cur_prev  <= r_prev[rd_idx];
        r_cur_refs  <= r_refs[rd_idx];
        r_cur_bytes <= r_bytes[rd_idx];
        r_cur_valid <= r_valid[rd_idx];
        case (i_cmd.op)
            OP_ATTACH: begin
                r_refs[r_cur] <= inc_ref;
                if (r_head != {1'b0, r_cur}) begin
                    // Unlink, then place at head; the old head is never r_cur here.
                    if (r_cur_next != NIL) r_prev[r_cur_next[IDX_W-1:0]] <= r_cur_prev;
                    r_next[r_cur_prev[IDX_W-1:0]] <= r_cur_next;
                    r_prev[r_head[IDX_W-1:0]] <= {1'b0, r_cur};
                    r_prev[r_cur] <= NIL;
                    r_next[r_cur] <= r_head;
                end
            end
            OP_DETACH: r_refs[r_cur] <= dec_ref;
            OP_REMOVE: begin
                if (r_cur_next != NIL) r_prev[r_cur_next[IDX_W-1:0]] <= r_cur_prev;
                if (r_cur_prev != NIL) r_next[r_cur_prev[IDX_W-1:0]] <= r_cur_next;
            end
            OP_ALLOC: begin
                r_refs[pop_idx]  <= REF_W'(1);
                r_bytes[pop_idx] <= r_req.new_size;
                r_prev[pop_idx]  <= NIL;
                r_next[pop_idx]  <= r_head;
                if (r_head != NIL) r_prev[r_head[IDX_W-1:0]] <= {1'b0, pop_idx};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_free_depth <= NIL;
            r_head       <= NIL;
            r_tail       <= NIL;
            r_total      <= '0;
            r_removed    <= '0;
            r_limit      <= '0;
            r_busy       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_free[i] <= IDX_W'(ENTRIES - 1 - i);
            end
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            case (i_cmd.op)
                OP_LOAD: r_busy <= '0;
                OP_ATTACH: begin
                    r_head <= {1'b0, r_cur};
                    if (r_head != {1'b0, r_cur} && r_tail == {1'b0, r_cur}) begin
                        r_tail <= r_cur_prev;
                    end
                end
                OP_REMOVE: begin
                    r_head         <= new_head;
                    r_tail         <= new_tail;
                    r_total        <= sub_total;
                    r_removed      <= r_removed + 1'b1;
                    r_valid[r_cur] <= 1'b0;
                    if (r_free_depth != NIL) begin
                        r_free[r_free_depth[IDX_W-1:0]] <= r_cur;
                        r_free_depth <= r_free_depth + 1'b1;
                    end
                end
                OP_SKIP_BUSY: r_busy <= r_busy + 1'b1;
                OP_ALLOC: begin
                    r_valid[pop_idx] <= 1'b1;
                    r_free_depth     <= pop_depth;
                    r_head           <= {1'b0, pop_idx};
                    if (r_tail == NIL) r_tail <= {1'b0, pop_idx};
                    r_total          <= add_total;
                end
                default: ;
            endcase
        end
    end

    // Result fields, registered with the operation that produced them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op inside {OP_ATTACH, OP_DETACH, OP_INVALID, OP_REMOVE, OP_ALLOC,
                             OP_NO_FREE, OP_SUMMARY}) begin
            o_rsp.status         <= ST_OK;
            o_rsp.result_index   <= r_cur;
            o_rsp.entry_size     <= r_cur_bytes;
            o_rsp.ref_count      <= r_cur_refs;
            o_rsp.is_removal     <= 1'b0;
            o_rsp.busy_count     <= '0;
            o_rsp.total_bytes    <= r_total;
            o_rsp.eviction_total <= r_removed;
            o_rsp.last           <= 1'b1;
            case (i_cmd.op)
                OP_ATTACH: o_rsp.ref_count <= inc_ref;
                OP_DETACH: o_rsp.ref_count <= dec_ref;
                OP_INVALID: begin
                    o_rsp.status       <= ST_INVALID;
                    o_rsp.result_index <= r_req.entry_index;
                    o_rsp.entry_size   <= '0;
                    o_rsp.ref_count    <= '0;
                end
                OP_REMOVE: begin
                    o_rsp.is_removal     <= 1'b1;
                    o_rsp.total_bytes    <= sub_total;
                    o_rsp.eviction_total <= r_removed + 1'b1;
                    o_rsp.last           <= 1'b0;
                end
                OP_ALLOC: begin
                    o_rsp.result_index <= pop_idx;
                    o_rsp.entry_size   <= r_req.new_size;
                    o_rsp.ref_count    <= REF_W'(1);
                    o_rsp.total_bytes  <= add_total;
                end
                OP_NO_FREE: begin
                    o_rsp.status       <= ST_NO_FREE;
                    o_rsp.result_index <= '0;
                    o_rsp.entry_size   <= '0;
                    o_rsp.ref_count    <= '0;
                end
                OP_SUMMARY: begin
                    o_rsp.result_index <= '0;
                    o_rsp.entry_size   <= '0;
                    o_rsp.ref_count    <= '0;
                    o_rsp.busy_count   <= r_busy;
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/lrc_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module lrc_ctrl import lrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_EVICT  = 8'b0000_1000,
        S_ALLOC  = 8'b0001_0000,
        S_WALK   = 8'b0010_0000,
        S_OUT    = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_evicting, n_evicting;
    logic   emit;

    assign o_ready = (r_state == S_IDLE) && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign emit    = !r_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid && !i_ready;
        n_evicting = r_evicting;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.op = OP_LOAD;
                n_state  = S_READ;
            end
            S_READ: begin
                o_cmd.op = (i_stat.cmd == CMD_ATTACH || i_stat.cmd == CMD_DETACH) ?
                    OP_READ_REQ : OP_READ_TAIL;
                n_evicting = i_stat.over_limit;
                n_state    = S_DECIDE;
            end
            S_DECIDE: if (emit) begin
                case (i_stat.cmd)
                    CMD_ATTACH, CMD_DETACH: begin
                        o_cmd.op = !i_stat.req_ok ? OP_INVALID :
                            (i_stat.cmd == CMD_ATTACH) ? OP_ATTACH : OP_DETACH;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_ADD: n_state = (r_evicting && !i_stat.cur_nil) ? S_EVICT : S_ALLOC;
                    default: n_state = S_WALK;
                endcase
            end
            S_EVICT: if (emit) begin
                o_cmd.op = OP_REMOVE;
                n_valid  = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // Re-read the new tail after the removal has settled.
                o_cmd.op = OP_READ_TAIL;
                n_state  = S_FINAL;
            end
            S_FINAL: begin
                n_state = (i_stat.under_limit || i_stat.cur_nil) ? S_ALLOC : S_EVICT;
            end
            S_ALLOC: if (emit) begin
                o_cmd.op = i_stat.free_empty ? OP_NO_FREE : OP_ALLOC;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            S_WALK: if (emit) begin
                if (i_stat.cur_nil) begin
                    o_cmd.op = OP_SUMMARY;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_stat.cur_busy) begin
                    o_cmd.op = OP_SKIP_BUSY;
                end else begin
                    o_cmd.op = OP_REMOVE;
                    n_valid  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_evicting <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_evicting <= n_evicting;
        end
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the byte budget LRU cache with reference counts.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lrc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [TOTAL_W-1:0] i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_req               i_req = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_rsp               o_rsp;

    lru_refcount_byte_budget_cache u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp)
    );

    // Shadow copy of the cache bookkeeping.
    logic [LINK_W-1:0]  nxt [ENTRIES];
    logic [LINK_W-1:0]  prv [ENTRIES];
    logic               vld [ENTRIES];
    logic [REF_W-1:0]   refs [ENTRIES];
    logic [SIZE_W-1:0]  bytes_of [ENTRIES];
    logic [IDX_W-1:0]   free_stack [ENTRIES];
    int                 free_depth;
    logic [LINK_W-1:0]  head, tail;
    logic [TOTAL_W-1:0] total, budget;
    logic [CNT_W-1:0]   removed;

    t_req pending_req [$];
    t_rsp expected_rsp [$];
    int   errors = 0;
    bit   idle_on = 1'b1;
    int   src_gap = 0;
    int   snk_gap = 0;
    int   long_req = 0;
    int   long_seen = 0;
    int   long_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[lru_refcount_byte_budget_cache] ERROR");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic note_result(logic [1:0] st, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] sz,
                               logic [REF_W-1:0] rc, logic rem, logic [BUSY_W-1:0] busy,
                               logic lst);
        t_rsp r;
        r.status = st;
        r.result_index = idx;
        r.entry_size = sz;
        r.ref_count = rc;
        r.is_removal = rem;
        r.busy_count = busy;
        r.total_bytes = total;
        r.eviction_total = removed;
        r.last = lst;
        expected_rsp.push_back(r);
    endtask

    task automatic unlink(int i);
        logic [LINK_W-1:0] n, p;
        n = nxt[i];
        p = prv[i];
        if (head == i) head = n;
        if (tail == i) tail = p;
        if (n < ENTRIES) prv[n] = p;
        if (p < ENTRIES) nxt[p] = n;
    endtask

    task automatic link_head(int i);
        if (head < ENTRIES) prv[head] = LINK_W'(i);
        prv[i] = NIL;
        nxt[i] = head;
        head = LINK_W'(i);
        if (tail >= ENTRIES) tail = LINK_W'(i);
    endtask

    task automatic drop_entry(int i);
        unlink(i);
        total = (total >= bytes_of[i]) ? total - bytes_of[i] : '0;
        removed++;
        vld[i] = 1'b0;
        if (free_depth < ENTRIES) begin
            free_stack[free_depth] = IDX_W'(i);
            free_depth++;
        end
    endtask

    task automatic predict_request(t_req q);
        int i, p, guard, busy;
        logic [TOTAL_W:0] sum;
        i = q.entry_index;
        if (q.cmd == CMD_ATTACH || q.cmd == CMD_DETACH) begin
            if (!vld[i]) begin
                note_result(ST_INVALID, q.entry_index, '0, '0, 1'b0, '0, 1'b1);
            end else begin
                if (q.cmd == CMD_ATTACH) begin
                    if (refs[i] != REF_MAX) refs[i]++;
                    unlink(i);
                    link_head(i);
                end else if (refs[i] != 0) begin
                    refs[i]--;
                end
                note_result(ST_OK, q.entry_index, bytes_of[i], refs[i], 1'b0, '0, 1'b1);
            end
        end else if (q.cmd == CMD_ADD) begin
            if (total > budget) begin
                for (guard = 0; guard < ENTRIES && tail < ENTRIES; guard++) begin
                    i = tail;
                    drop_entry(i);
                    note_result(ST_OK, IDX_W'(i), bytes_of[i], refs[i], 1'b1, '0, 1'b0);
                    if (total < budget) break;
                end
            end
            if (free_depth == 0) begin
                note_result(ST_NO_FREE, '0, '0, '0, 1'b0, '0, 1'b1);
            end else begin
                free_depth--;
                i = free_stack[free_depth];
                vld[i] = 1'b1;
                refs[i] = 1;
                bytes_of[i] = q.new_size;
                link_head(i);
                sum = {1'b0, total} + q.new_size;
                total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                note_result(ST_OK, IDX_W'(i), q.new_size, REF_W'(1), 1'b0, '0, 1'b1);
            end
        end else begin
            busy = 0;
            i = tail;
            for (guard = 0; guard < ENTRIES && i < ENTRIES; guard++) begin
                p = prv[i];
                if (refs[i] != 0) begin
                    busy++;
                end else begin
                    drop_entry(i);
                    note_result(ST_OK, IDX_W'(i), bytes_of[i], '0, 1'b1, '0, 1'b0);
                end
                i = p;
            end
            note_result(ST_OK, '0, '0, '0, 1'b0, BUSY_W'(busy), 1'b1);
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_request(i_req);
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_req.size() != 0) begin
                    i_req <= pending_req.pop_front();
                    i_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready generation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_rsp), 64'd0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", 64'(o_rsp.status), 64'(want.status));
                    if (o_rsp.result_index !== want.result_index)
                        report_mismatch("result_index", 64'(o_rsp.result_index),
                                        64'(want.result_index));
                    if (o_rsp.entry_size !== want.entry_size)
                        report_mismatch("entry_size", 64'(o_rsp.entry_size),
                                        64'(want.entry_size));
                    if (o_rsp.ref_count !== want.ref_count)
                        report_mismatch("ref_count", 64'(o_rsp.ref_count), 64'(want.ref_count));
                    if (o_rsp.is_removal !== want.is_removal)
                        report_mismatch("is_removal", 64'(o_rsp.is_removal),
                                        64'(want.is_removal));
                    if (o_rsp.busy_count !== want.busy_count)
                        report_mismatch("busy_count", 64'(o_rsp.busy_count),
                                        64'(want.busy_count));
                    if (o_rsp.total_bytes !== want.total_bytes)
                        report_mismatch("total_bytes", 64'(o_rsp.total_bytes),
                                        64'(want.total_bytes));
                    if (o_rsp.eviction_total !== want.eviction_total)
                        report_mismatch("eviction_total", 64'(o_rsp.eviction_total),
                                        64'(want.eviction_total));
                    if (o_rsp.last !== want.last)
                        report_mismatch("last", 64'(o_rsp.last), 64'(want.last));
                end
            end
            if (long_seen != long_req) begin
                long_seen = long_req;
                long_left = 600;
                i_ready <= 1'b0;
            end else if (long_left > 0) begin
                long_left--;
                i_ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 15);
            end
        end
    end

    task automatic queue_req(logic [1:0] c, int idx, logic [SIZE_W-1:0] sz);
        t_req q;
        q.cmd = c;
        q.entry_index = IDX_W'(idx);
        q.new_size = sz;
        pending_req.push_back(q);
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || i_valid || expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [TOTAL_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        budget = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(int mode);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (mode == 0 || r < 6) return SIZE_W'($urandom_range(1, 4000));
        return SIZE_W'($urandom);
    endfunction

    task automatic queue_random(int n, int mode);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) queue_req(CMD_ATTACH, $urandom_range(0, 31), SIZE_W'($urandom));
            else if (r < 70) queue_req(CMD_ADD, $urandom_range(0, 31), pick_size(mode));
            else if (r < 92) queue_req(CMD_DETACH, $urandom_range(0, 31), SIZE_W'($urandom));
            else queue_req(CMD_CLEAR, $urandom_range(0, 31), SIZE_W'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            nxt[i] = '0;
            prv[i] = '0;
            vld[i] = 1'b0;
            refs[i] = '0;
            bytes_of[i] = '0;
            free_stack[i] = IDX_W'(ENTRIES - 1 - i);
        end
        free_depth = ENTRIES;
        head = NIL;
        tail = NIL;
        total = '0;
        removed = '0;
        budget = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reference counts up and down to the zero floor, without idling.
        idle_on = 1'b0;
        write_budget(TOTAL_MAX);
        queue_req(CMD_ADD, 0, 32'd7);
        for (int k = 0; k < 3; k++) queue_req(CMD_ATTACH, 0, '0);
        for (int k = 0; k < 5; k++) queue_req(CMD_DETACH, 0, '0);
        wait_idle();
        idle_on = 1'b1;

        // Directed corner cases.
        queue_req(CMD_ADD, 31, '1);
        queue_req(CMD_ADD, 0, '0);
        queue_req(CMD_ATTACH, 1, '0);
        queue_req(CMD_ATTACH, 31, '1);
        queue_req(CMD_DETACH, 2, '0);
        queue_req(CMD_DETACH, 2, '0);
        queue_req(CMD_DETACH, 30, '0);
        queue_req(CMD_CLEAR, 0, '0);
        for (int k = 0; k < 12; k++) queue_req(CMD_ADD, k, '1);
        queue_req(CMD_CLEAR, 31, '1);
        wait_idle();
        write_budget('0);
        queue_req(CMD_ADD, 5, 32'd100);
        queue_req(CMD_ADD, 6, 32'd1);
        queue_req(CMD_CLEAR, 0, '0);
        wait_idle();

        write_budget(TOTAL_MAX);
        queue_random(75, 0);
        wait_idle();
        write_budget(TOTAL_W'(20000));
        long_req++;
        queue_random(75, 0);
        wait_idle();
        write_budget({6'($urandom_range(0, 63)), 32'($urandom)});
        queue_random(75, 1);
        wait_idle();
        write_budget('0);
        queue_random(75, 1);
        wait_idle();
        write_budget(TOTAL_W'($urandom_range(1, 60000)));
        idle_on = 1'b0;
        queue_random(75, 0);
        wait_idle();

        if (errors == 0 && expected_rsp.size() == 0) begin
            $display("[lru_refcount_byte_budget_cache] OK");
        end else begin
            $display("[lru_refcount_byte_budget_cache] ERROR");
        end
        $finish;
    end
endmodule

FILE: lru_refcount_byte_budget_cache.f
rtl/lrc_pkg.sv
rtl/lrc_datapath.sv
rtl/lrc_ctrl.sv
rtl/lru_refcount_byte_budget_cache.sv
tb/testbench.sv
